// ----- rtl/acbio_pkg.sv -----
// Shared types and constants of the arcade console CPU bus I/O block.
`timescale 1ns / 1ps
`default_nettype none

package acbio_pkg;

  localparam int RAM_DEPTH     = 2048;
  localparam int RAM_AW        = $clog2(RAM_DEPTH);
  localparam int CHR_BANK_SIZE = 8192;
  localparam int CHR_AW        = $clog2(CHR_BANK_SIZE);

  localparam logic [7:0]  DIP_RESET   = 8'h10;
  localparam logic [7:0]  COIN_MASK   = 8'h64;
  localparam logic [7:0]  DIP_P1_MASK = 8'hfc;

  localparam logic [15:0] ADDR_PPU     = 16'h2000;
  localparam logic [15:0] ADDR_IO      = 16'h4000;
  localparam logic [15:0] ADDR_DMA     = 16'h4014;
  localparam logic [15:0] ADDR_PORT0   = 16'h4016;
  localparam logic [15:0] ADDR_PORT1   = 16'h4017;
  localparam logic [15:0] ADDR_COUNTER = 16'h4020;
  localparam logic [15:0] ADDR_XRAM    = 16'h6000;
  localparam logic [15:0] ADDR_PRG     = 16'h8000;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_FETCH = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    FWD_NONE      = 3'd0,
    FWD_PPU_READ  = 3'd1,
    FWD_PPU_WRITE = 3'd2,
    FWD_APU_WRITE = 3'd3,
    FWD_OAM_DMA   = 3'd4,
    FWD_PRG_READ  = 3'd5,
    FWD_CHR_READ  = 3'd6
  } fwd_kind_t;

  typedef enum logic [1:0] {
    SRC_LOCAL = 2'd0,
    SRC_WORK  = 2'd1,
    SRC_EXTRA = 2'd2
  } rd_src_t;

endpackage

`default_nettype wire

// ----- rtl/arcade_console_cpu_bus_io_top.sv -----
// Latency: result is presented the cycle after the transaction is accepted.
// Throughput: one bus transaction per cycle while the output is not stalled and no clearing
// pass runs; decode and state update in one pass. Read data of the two RAMs comes straight from
// their registered read ports. Reset: synchronous; a clearing pass then zeroes all 2048 addresses
// of both RAMs, one address per cycle, with in_ready held low. Config writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module arcade_console_cpu_bus_io_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,
  // bus access in
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  write_data,
  input  wire logic [7:0]  pad0,
  input  wire logic [7:0]  pad1,
  input  wire logic [7:0]  coin_bits,
  // result out
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       read_data,
  output logic [2:0]       forward_kind,
  output logic [15:0]      forward_address,
  output logic [7:0]       forward_data,
  output logic [15:0]      coin_count,
  output logic             chr_bank_now,
  output logic             ram_ctl_now
);

  import acbio_pkg::*;

  // state
  logic [7:0]  dip_switches;
  logic [7:0]  latch0, latch1;
  logic        strobe, bank_select, ram_ctl;
  logic        coin_line;
  logic [15:0] coin_total;
  logic [7:0]  coin_latch;
  logic              clearing;
  logic [RAM_AW-1:0] clr_addr;

  // result registers
  logic [7:0]  rd_local;
  rd_src_t     rd_src;
  logic [2:0]  fwd_kind;
  logic [15:0] fwd_addr;
  logic [7:0]  fwd_data;

  // next values
  logic [7:0]  latch0_next, latch1_next;
  logic        strobe_next, bank_select_next, ram_ctl_next;
  logic        coin_line_next;
  logic [15:0] coin_total_next;
  logic [7:0]  coin_latch_next;
  logic [7:0]  rd_local_next;
  rd_src_t     rd_src_next;
  fwd_kind_t   fwd_kind_next;
  logic [15:0] fwd_addr_next;
  logic [7:0]  fwd_data_next;
  logic        wram_wr, xram_wr;

  // decode temporaries
  logic        feed, feed_val;
  logic [7:0]  port_val;
  logic        port_bit;
  logic [15:0] cnt_off;

  logic        accept;
  logic              ram_we_w, ram_we_x, ram_re_w, ram_re_x;
  logic [RAM_AW-1:0] ram_addr;
  logic [7:0]        ram_wdata;
  logic [7:0]        wram_dout, xram_dout;

  assign cfg_ready = 1'b1;
  assign in_ready  = !clearing && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;

  always_comb begin
    latch0_next       = latch0;
    latch1_next       = latch1;
    strobe_next       = strobe;
    bank_select_next  = bank_select;
    ram_ctl_next      = ram_ctl;
    coin_latch_next   = coin_latch;
    rd_local_next     = 8'h00;
    rd_src_next       = SRC_LOCAL;
    fwd_kind_next     = FWD_NONE;
    fwd_addr_next     = 16'h0000;
    fwd_data_next     = 8'h00;
    wram_wr           = 1'b0;
    xram_wr           = 1'b0;
    feed              = 1'b0;
    feed_val          = 1'b0;
    cnt_off           = address - ADDR_COUNTER;
    // strobe high means the latch reloads from its pad before the shift
    port_val          = address[0] ? (strobe ? pad1 : latch1) : (strobe ? pad0 : latch0);
    port_bit          = port_val[0];

    case (mode)
      MODE_READ: begin
        if (address < ADDR_PPU) begin
          rd_src_next = SRC_WORK;
        end else if (address < ADDR_IO) begin
          fwd_kind_next = FWD_PPU_READ;
          fwd_addr_next = ADDR_PPU | {13'h0000, address[2:0]};
        end else if (address == ADDR_PORT0 || address == ADDR_PORT1) begin
          if (address[0]) begin
            latch1_next   = {1'b0, port_val[7:1]};
            rd_local_next = (dip_switches & DIP_P1_MASK) | {7'h00, port_bit};
          end else begin
            latch0_next   = {1'b0, port_val[7:1]};
            rd_local_next = (coin_bits & COIN_MASK) | {3'b000, dip_switches[1:0], 3'b000}
                            | {7'h00, port_bit};
          end
        end else if (address >= ADDR_COUNTER && address < ADDR_XRAM) begin
          rd_local_next = coin_latch;
          feed          = 1'b1;
          feed_val      = cnt_off[8];
        end else if (address >= ADDR_XRAM && address < ADDR_PRG) begin
          rd_src_next = SRC_EXTRA;
        end else if (address >= ADDR_PRG) begin
          fwd_kind_next = FWD_PRG_READ;
          fwd_addr_next = address - ADDR_PRG;
        end
      end
      MODE_WRITE: begin
        if (address < ADDR_PPU) begin
          wram_wr = 1'b1;
        end else if (address < ADDR_IO) begin
          fwd_kind_next = FWD_PPU_WRITE;
          fwd_addr_next = ADDR_PPU | {13'h0000, address[2:0]};
          fwd_data_next = write_data;
        end else if (address == ADDR_PORT0) begin
          // falling strobe captures both pads
          if (strobe && !write_data[0]) begin
            latch0_next = pad0;
            latch1_next = pad1;
          end
          strobe_next      = write_data[0];
          bank_select_next = write_data[2];
          ram_ctl_next     = write_data[1];
        end else if (address == ADDR_DMA) begin
          fwd_kind_next = FWD_OAM_DMA;
          fwd_addr_next = {write_data, 8'h00};
        end else if (address < ADDR_COUNTER) begin
          fwd_kind_next = FWD_APU_WRITE;
          fwd_addr_next = address;
          fwd_data_next = write_data;
        end else if (address < ADDR_XRAM) begin
          feed            = 1'b1;
          feed_val        = write_data[0];
          coin_latch_next = write_data;
        end else if (address < ADDR_PRG) begin
          xram_wr = 1'b1;
        end
      end
      MODE_FETCH: begin
        fwd_kind_next = FWD_CHR_READ;
        fwd_addr_next = (16'(bank_select) << CHR_AW) | 16'(address[CHR_AW-1:0]);
      end
      default: begin
      end
    endcase

    // coin counter counts rising edges of the fed line
    coin_line_next  = coin_line;
    coin_total_next = coin_total;
    if (feed) begin
      coin_line_next = feed_val;
      if (feed_val && !coin_line) begin
        coin_total_next = coin_total + 16'd1;
      end
    end
  end

  // RAM port control: clearing pass owns the ports after reset
  always_comb begin
    if (clearing) begin
      ram_addr  = clr_addr;
      ram_wdata = 8'h00;
      ram_we_w  = 1'b1;
      ram_we_x  = 1'b1;
      ram_re_w  = 1'b0;
      ram_re_x  = 1'b0;
    end else begin
      ram_addr  = address[RAM_AW-1:0];
      ram_wdata = write_data;
      ram_we_w  = accept && wram_wr;
      ram_we_x  = accept && xram_wr;
      ram_re_w  = accept && (rd_src_next == SRC_WORK);
      ram_re_x  = accept && (rd_src_next == SRC_EXTRA);
    end
  end

  acbio_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_work_ram (
    .clk   (clk),
    .we    (ram_we_w),
    .re    (ram_re_w),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (wram_dout)
  );

  acbio_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_extra_ram (
    .clk   (clk),
    .we    (ram_we_x),
    .re    (ram_re_x),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (xram_dout)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dip_switches <= DIP_RESET;
      latch0       <= 8'h00;
      latch1       <= 8'h00;
      strobe       <= 1'b0;
      bank_select  <= 1'b0;
      ram_ctl      <= 1'b0;
      coin_line    <= 1'b0;
      coin_total   <= 16'h0000;
      coin_latch   <= 8'h00;
      clearing     <= 1'b1;
      clr_addr     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dip_switches <= cfg_data;
      end
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == RAM_AW'(RAM_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (accept) begin
        latch0       <= latch0_next;
        latch1       <= latch1_next;
        strobe       <= strobe_next;
        bank_select  <= bank_select_next;
        ram_ctl      <= ram_ctl_next;
        coin_line    <= coin_line_next;
        coin_total   <= coin_total_next;
        coin_latch   <= coin_latch_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_local <= rd_local_next;
      rd_src   <= rd_src_next;
      fwd_kind <= fwd_kind_next;
      fwd_addr <= fwd_addr_next;
      fwd_data <= fwd_data_next;
    end
  end

  // RAM read ports only move on accept, so this holds while stalled
  always_comb begin
    case (rd_src)
      SRC_WORK:  read_data = wram_dout;
      SRC_EXTRA: read_data = xram_dout;
      default:   read_data = rd_local;
    endcase
  end

  // state registers only change on accept, so they show the post-access values
  assign forward_kind    = fwd_kind;
  assign forward_address = fwd_addr;
  assign forward_data    = fwd_data;
  assign coin_count      = coin_total;
  assign chr_bank_now    = bank_select;
  assign ram_ctl_now     = ram_ctl;

endmodule

`default_nettype wire

// ----- rtl/acbio_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module acbio_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ----- dv/tb_arcade_console_cpu_bus_io_top.sv -----
// Self-checking testbench for the arcade console CPU bus decoder and local I/O block.
`timescale 1ns / 1ps

module tb_arcade_console_cpu_bus_io_top;
  import acbio_pkg::*;

  localparam logic [1:0] MODE_NONE  = 2'd3;   // unused mode code, no access
  localparam int         CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  pad0;
    logic [7:0]  pad1;
    logic [7:0]  coin_bits;
  } bus_access_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [2:0]  kind;
    logic [15:0] fwd_addr;
    logic [7:0]  fwd_data;
    logic [15:0] coins;
    logic        bank;
    logic        ram_ctl;
  } bus_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = 2'd0;
  logic [15:0] address = 16'h0000;
  logic [7:0]  write_data = 8'h00;
  logic [7:0]  pad0 = 8'h00;
  logic [7:0]  pad1 = 8'h00;
  logic [7:0]  coin_bits = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  read_data;
  logic [2:0]  forward_kind;
  logic [15:0] forward_address;
  logic [7:0]  forward_data;
  logic [15:0] coin_count;
  logic        chr_bank_now;
  logic        ram_ctl_now;

  arcade_console_cpu_bus_io_top dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .mode            (mode),
    .address         (address),
    .write_data      (write_data),
    .pad0            (pad0),
    .pad1            (pad1),
    .coin_bits       (coin_bits),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .read_data       (read_data),
    .forward_kind    (forward_kind),
    .forward_address (forward_address),
    .forward_data    (forward_data),
    .coin_count      (coin_count),
    .chr_bank_now    (chr_bank_now),
    .ram_ctl_now     (ram_ctl_now)
  );

  // Predictor state
  logic [7:0]  work_mem [RAM_DEPTH];
  logic [7:0]  extra_mem [RAM_DEPTH];
  logic [7:0]  pad_shift [2];
  logic        strobe_q, bank_q, ram_ctl_q, coin_line_q;
  logic [15:0] coin_total_q;
  logic [7:0]  coin_latch_q;
  logic [7:0]  dip_model = DIP_RESET;

  bus_access_t pending_access[$];
  bus_result_t expected_results[$];
  bus_access_t next_access;
  int          queued_count = 0;
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          cycle_count = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void feed_coin_line(input logic line);
    if (line && !coin_line_q) coin_total_q = coin_total_q + 16'd1;
    coin_line_q = line;
  endfunction

  function automatic bus_result_t predict_access(input bus_access_t acc);
    bus_result_t r;
    logic [15:0] a;
    logic [15:0] off;
    logic [7:0]  wd;
    logic        p;
    logic        b;
    r  = '0;
    a  = acc.address;
    wd = acc.write_data;
    case (acc.mode)
      MODE_READ: begin
        if (a < ADDR_PPU) begin
          r.read_data = work_mem[a[RAM_AW-1:0]];
        end else if (a < ADDR_IO) begin
          r.kind     = FWD_PPU_READ;
          r.fwd_addr = ADDR_PPU | {13'd0, a[2:0]};
        end else if (a == ADDR_PORT0 || a == ADDR_PORT1) begin
          p = a[0];
          if (strobe_q) pad_shift[p] = p ? acc.pad1 : acc.pad0;
          b = pad_shift[p][0];
          pad_shift[p] = pad_shift[p] >> 1;
          if (p)
            r.read_data = {dip_model[7:2], 1'b0, b};
          else
            r.read_data = (acc.coin_bits & COIN_MASK) | {3'b000, dip_model[1:0], 2'b00, b};
        end else if (a >= ADDR_COUNTER && a < ADDR_XRAM) begin
          r.read_data = coin_latch_q;
          off = a - ADDR_COUNTER;
          feed_coin_line(off[8]);
        end else if (a >= ADDR_XRAM && a < ADDR_PRG) begin
          r.read_data = extra_mem[a[RAM_AW-1:0]];
        end else if (a >= ADDR_PRG) begin
          r.kind     = FWD_PRG_READ;
          r.fwd_addr = a - ADDR_PRG;
        end
      end
      MODE_WRITE: begin
        if (a < ADDR_PPU) begin
          work_mem[a[RAM_AW-1:0]] = wd;
        end else if (a < ADDR_IO) begin
          r.kind     = FWD_PPU_WRITE;
          r.fwd_addr = ADDR_PPU | {13'd0, a[2:0]};
          r.fwd_data = wd;
        end else if (a == ADDR_PORT0) begin
          // falling strobe latches both pads
          if (strobe_q && !wd[0]) begin
            pad_shift[0] = acc.pad0;
            pad_shift[1] = acc.pad1;
          end
          strobe_q  = wd[0];
          bank_q    = wd[2];
          ram_ctl_q = wd[1];
        end else if (a == ADDR_DMA) begin
          r.kind     = FWD_OAM_DMA;
          r.fwd_addr = {wd, 8'h00};
        end else if (a < ADDR_COUNTER) begin
          r.kind     = FWD_APU_WRITE;
          r.fwd_addr = a;
          r.fwd_data = wd;
        end else if (a < ADDR_XRAM) begin
          feed_coin_line(wd[0]);
          coin_latch_q = wd;
        end else if (a < ADDR_PRG) begin
          extra_mem[a[RAM_AW-1:0]] = wd;
        end
      end
      MODE_FETCH: begin
        r.kind     = FWD_CHR_READ;
        r.fwd_addr = {2'b00, bank_q, a[CHR_AW-1:0]};
      end
      default: ;
    endcase
    r.coins   = coin_total_q;
    r.bank    = bank_q;
    r.ram_ctl = ram_ctl_q;
    return r;
  endfunction

  // Driver: presents queued bus accesses, holding each until it is accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_access.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_access  = pending_access.pop_front();
        in_valid     <= 1'b1;
        mode         <= next_access.mode;
        address      <= next_access.address;
        write_data   <= next_access.write_data;
        pad0         <= next_access.pad0;
        pad1         <= next_access.pad1;
        coin_bits    <= next_access.coin_bits;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transaction, then predicts for the accepted access
  always @(posedge clk) begin : monitor
    bus_result_t got;
    bus_result_t want;
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{read_data, forward_kind, forward_address, forward_data,
                coin_count, chr_bank_now, ram_ctl_now};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: rd=%h kind=%0d fa=%h fd=%h coin=%h bank=%b rc=%b",
                     got.read_data, got.kind, got.fwd_addr, got.fwd_data, got.coins,
                     got.bank, got.ram_ctl);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: exp rd=%h kind=%0d fa=%h fd=%h coin=%h bank=%b rc=%b",
                       want.read_data, want.kind, want.fwd_addr, want.fwd_data, want.coins,
                       want.bank, want.ram_ctl);
              $display("          act rd=%h kind=%0d fa=%h fd=%h coin=%h bank=%b rc=%b",
                       got.read_data, got.kind, got.fwd_addr, got.fwd_data, got.coins,
                       got.bank, got.ram_ctl);
            end
          end
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(predict_access('{mode, address, write_data, pad0, pad1,
                                                    coin_bits}));
    end
  end

  task automatic queue_access(input logic [1:0] m, input logic [15:0] a, input logic [7:0] wd);
    bus_access_t acc;
    acc.mode         = m;
    acc.address      = a;
    acc.write_data   = wd;
    acc.pad0         = 8'($urandom);
    acc.pad1         = 8'($urandom);
    acc.coin_bits    = 8'($urandom);
    pending_access.push_back(acc);
    queued_count++;
  endtask

  function automatic logic [15:0] pick_address();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25)      return 16'($urandom);
    else if (r < 40) return 16'($urandom_range(16'h1fff));
    else if (r < 50) return 16'($urandom_range(16'h3fff, 16'h2000));
    else if (r < 65) return ADDR_IO + 16'($urandom_range(31));
    else if (r < 75) return 16'($urandom_range(16'h5fff, 16'h4020));
    else if (r < 88) return 16'($urandom_range(16'h7fff, 16'h6000));
    else             return 16'($urandom_range(16'hffff, 16'h8000));
  endfunction

  function automatic logic [1:0] pick_mode();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45)      return MODE_READ;
    else if (r < 85) return MODE_WRITE;
    else if (r < 95) return MODE_FETCH;
    else             return MODE_NONE;
  endfunction

  // RAM address with random mirror bits above the 2 KB index
  function automatic logic [15:0] ram_alias(input logic xram, input logic [15:0] idx);
    return {xram ? 3'b011 : 3'b000, 2'($urandom), idx[10:0]};
  endfunction

  task automatic queue_random(input int n);
    int          target;
    int unsigned sel;
    int unsigned len;
    int unsigned i;
    logic        xram;
    logic [15:0] base;
    target = queued_count + n;
    while (queued_count < target) begin
      sel = $urandom_range(99);
      if (sel < 25) begin
        // controller poll: strobe high, an optional read, strobe low, then shift the bits out
        queue_access(MODE_WRITE, ADDR_PORT0, {7'($urandom), 1'b1});
        if ($urandom_range(3) == 0)
          queue_access(MODE_READ, ADDR_PORT0 | 16'($urandom_range(1)), 8'($urandom));
        queue_access(MODE_WRITE, ADDR_PORT0, {7'($urandom), 1'b0});
        len = $urandom_range(10, 6);
        for (i = 0; i < len; i++)
          queue_access(MODE_READ, ADDR_PORT0 | 16'($urandom_range(1)), 8'($urandom));
      end else if (sel < 40) begin
        for (i = 0; i < 4; i++)
          queue_access($urandom_range(1) ? MODE_WRITE : MODE_READ,
                       16'($urandom_range(16'h5fff, 16'h4020)), 8'($urandom));
      end else if (sel < 60) begin
        xram = 1'($urandom_range(1));
        base = 16'($urandom_range(RAM_DEPTH - 1));
        len  = $urandom_range(6, 2);
        for (i = 0; i < len; i++)
          queue_access(MODE_WRITE, ram_alias(xram, base + 16'(i)), 8'($urandom));
        for (i = 0; i < len; i++)
          queue_access(MODE_READ, ram_alias(xram, base + 16'(i)), 8'($urandom));
      end else begin
        queue_access(pick_mode(), pick_address(), 8'($urandom));
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_access.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_dips(input logic [7:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dip_model = v;
    @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  initial begin
    for (int i = 0; i < RAM_DEPTH; i++) begin
      work_mem[i]  = 8'h00;
      extra_mem[i] = 8'h00;
    end
    pad_shift[0] = 8'h00;
    pad_shift[1] = 8'h00;
    strobe_q     = 1'b0;
    bank_q       = 1'b0;
    ram_ctl_q    = 1'b0;
    coin_line_q  = 1'b0;
    coin_total_q = 16'h0000;
    coin_latch_q = 8'h00;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    set_idling(38, 84);

    // directed accesses, DIP switches at their reset value
    queue_access(MODE_READ,  16'h0000, 8'h00);
    queue_access(MODE_WRITE, 16'h07ff, 8'hff);
    queue_access(MODE_READ,  16'h1fff, 8'h00);
    queue_access(MODE_READ,  16'h2000, 8'h00);
    queue_access(MODE_WRITE, 16'h3fff, 8'ha5);
    queue_access(MODE_WRITE, ADDR_DMA, 8'hff);
    queue_access(MODE_WRITE, ADDR_IO,  8'h00);
    queue_access(MODE_WRITE, ADDR_PORT1, 8'h5a);
    queue_access(MODE_READ,  ADDR_IO,  8'h00);
    queue_access(MODE_READ,  16'h401f, 8'h00);
    queue_access(MODE_WRITE, ADDR_PORT0, 8'h07);
    queue_access(MODE_FETCH, 16'hffff, 8'h00);
    queue_access(MODE_READ,  ADDR_PORT0, 8'h00);
    queue_access(MODE_READ,  ADDR_PORT1, 8'h00);
    queue_access(MODE_WRITE, ADDR_PORT0, 8'h00);
    queue_access(MODE_READ,  ADDR_PORT0, 8'h00);
    queue_access(MODE_READ,  ADDR_PORT1, 8'h00);
    queue_access(MODE_WRITE, ADDR_COUNTER, 8'h01);
    queue_access(MODE_READ,  16'h5fff, 8'h00);
    queue_access(MODE_READ,  ADDR_COUNTER, 8'h00);
    queue_access(MODE_READ,  16'h4120, 8'h00);
    queue_access(MODE_WRITE, ADDR_XRAM, 8'haa);
    queue_access(MODE_READ,  16'h6800, 8'h00);
    queue_access(MODE_READ,  ADDR_PRG, 8'h00);
    queue_access(MODE_READ,  16'hffff, 8'h00);
    queue_access(MODE_WRITE, 16'hffff, 8'h55);
    queue_access(MODE_FETCH, 16'h0000, 8'h00);
    queue_access(MODE_NONE,  16'hffff, 8'hff);
    wait_idle();

    write_dips(8'hff);
    queue_random(350);
    wait_idle();

    write_dips(8'h00);
    set_idling(84, 38);
    queue_random(175);
    // hold off new accesses until every outstanding result is back
    wait_idle();
    queue_random(175);
    wait_idle();

    write_dips(8'($urandom));
    set_idling(0, 0);
    queue_random(350);
    wait_idle();

    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
